// ===== hdl/asnt_pkg.sv =====
// ============================================================================
// asnt_pkg: shared types and constants for the ADC scan averager
// Scan sizes, record type between front and back, NTC lookup table.
// ============================================================================
package asnt_pkg;

  localparam int AVG_LOG2      = 6;
  localparam int NUM_SLOTS     = 10;
  localparam int TABLE_ENTRIES = 166;
  localparam int SAMPLE_BITS   = 12;
  localparam int TEMP_OFFSET   = 40;
  localparam int TEMP_MAX      = TABLE_ENTRIES - 1 - TEMP_OFFSET;

  localparam int SLOT_W = 4;
  localparam int CNT_W  = AVG_LOG2 + 1;
  localparam int SUM_W  = SAMPLE_BITS + AVG_LOG2;
  localparam int IDX_W  = 8;
  localparam int TEMP_W = 8;

  localparam logic [CNT_W-1:0]  AVG_COUNT  = CNT_W'(2 ** AVG_LOG2);
  localparam logic [SLOT_W-1:0] SLOT_TEMP  = SLOT_W'(NUM_SLOTS - 2);
  localparam logic [SLOT_W-1:0] SLOT_VOLT  = SLOT_W'(NUM_SLOTS - 1);
  localparam logic [IDX_W-1:0]  IDX_LAST   = IDX_W'(TABLE_ENTRIES - 1);

  // front-to-back queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef struct packed {
    logic [SLOT_W-1:0]      next_slot;
    logic                   avg_valid;
    logic [SLOT_W-1:0]      avg_slot;
    logic [SAMPLE_BITS-1:0] avg_value;
    logic                   round_done;
    logic [SAMPLE_BITS-1:0] temp_code;
  } scan_rec_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SEARCH,
    BK_PREP,
    BK_NUM,
    BK_DIV,
    BK_DONE
  } back_state_e;

  // entry i is the ADC code at (i - TEMP_OFFSET) degrees C
  localparam logic [SAMPLE_BITS-1:0] NTC_ROM [TABLE_ENTRIES] = '{
    12'h05F, 12'h066, 12'h06E, 12'h075, 12'h07E, 12'h087, 12'h090, 12'h09A,
    12'h0A5, 12'h0B0, 12'h0BC, 12'h0C8, 12'h0D5, 12'h0E3, 12'h0F2, 12'h101,
    12'h111, 12'h122, 12'h133, 12'h146, 12'h159, 12'h16D, 12'h182, 12'h198,
    12'h1AF, 12'h1C7, 12'h1E0, 12'h1F9, 12'h214, 12'h22F, 12'h24C, 12'h26A,
    12'h288, 12'h2A7, 12'h2C8, 12'h2E9, 12'h30C, 12'h32F, 12'h353, 12'h378,
    12'h39E, 12'h3C5, 12'h3EC, 12'h414, 12'h43D, 12'h467, 12'h492, 12'h4BD,
    12'h4E8, 12'h514, 12'h541, 12'h56E, 12'h59B, 12'h5C9, 12'h5F7, 12'h626,
    12'h654, 12'h683, 12'h6B1, 12'h6E0, 12'h70F, 12'h73D, 12'h76C, 12'h79A,
    12'h7C8, 12'h7F6, 12'h823, 12'h850, 12'h87D, 12'h8A9, 12'h8D5, 12'h900,
    12'h92B, 12'h955, 12'h97F, 12'h9A8, 12'h9D0, 12'h9F8, 12'hA1F, 12'hA45,
    12'hA6B, 12'hA90, 12'hAB4, 12'hAD7, 12'hAFA, 12'hB1C, 12'hB3D, 12'hB5E,
    12'hB7D, 12'hB9C, 12'hBBB, 12'hBD8, 12'hBF5, 12'hC11, 12'hC2C, 12'hC47,
    12'hC61, 12'hC7A, 12'hC92, 12'hCAA, 12'hCC2, 12'hCD8, 12'hCEE, 12'hD04,
    12'hD18, 12'hD2C, 12'hD40, 12'hD53, 12'hD66, 12'hD77, 12'hD89, 12'hD9A,
    12'hDAA, 12'hDBA, 12'hDC9, 12'hDD8, 12'hDE7, 12'hDF5, 12'hE03, 12'hE10,
    12'hE1D, 12'hE29, 12'hE35, 12'hE41, 12'hE4C, 12'hE57, 12'hE62, 12'hE6C,
    12'hE76, 12'hE80, 12'hE8A, 12'hE93, 12'hE9C, 12'hEA4, 12'hEAD, 12'hEB5,
    12'hEBD, 12'hEC4, 12'hECC, 12'hED3, 12'hEDA, 12'hEE0, 12'hEE7, 12'hEED,
    12'hEF3, 12'hEF9, 12'hEFF, 12'hF05, 12'hF0A, 12'hF0F, 12'hF15, 12'hF1A,
    12'hF1E, 12'hF23, 12'hF28, 12'hF2C, 12'hF30, 12'hF35, 12'hF39, 12'hF3D,
    12'hF40, 12'hF44, 12'hF48, 12'hF4B, 12'hF4F, 12'hF52
  };

  // table read; indexes past the end return the last entry
  function automatic logic [SAMPLE_BITS-1:0] ntc_rom(input logic [IDX_W-1:0] idx);
    logic [SAMPLE_BITS-1:0] val;
    if (idx > IDX_LAST) begin
      val = NTC_ROM[TABLE_ENTRIES-1];
    end else begin
      val = NTC_ROM[idx];
    end
    return val;
  endfunction

endpackage

// ===== hdl/adc_scan_average_ntc_temperature.sv =====
// ============================================================================
// adc_scan_average_ntc_temperature: ADC scan averager with NTC temperature
// Top level: front sequencer, record queue and conversion back end.
// ============================================================================
// Usage:
//   Input side is a queue: drive sample_i and push; a beat is taken when
//   push is high and full is low. One beat per ADC conversion.
//   Output side is a queue: one result per input beat, shown while empty
//   is low, taken when pop is high. next_slot_o tells which slot to
//   convert next.
//   An ordinary beat passes through the queue entry and the output register.
//   A beat that completes the voltage slot (round_done_o) carries the
//   temperature and is delivered after eight table-search steps, the
//   multiply (BK_PREP), the numerator (BK_NUM) and eight divide steps.
//   Throughput: one beat per cycle for ordinary beats while the back end is
//   idle and the output is free; round-done beats occupy the back end until
//   delivered while the two-entry queue keeps taking beats until it fills.
//   Reset clears the scan position, the accumulator and the stored
//   temperature average; the queue and output register come up empty.
//   If the receiver stalls, the output register holds, the queue fills,
//   and full rises; no beat is lost.
// ============================================================================
module adc_scan_average_ntc_temperature (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  logic [asnt_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic                             empty,
  input  logic                             pop,
  output logic [asnt_pkg::SLOT_W-1:0]      next_slot_o,
  output logic                             avg_valid_o,
  output logic [asnt_pkg::SLOT_W-1:0]      avg_slot_o,
  output logic [asnt_pkg::SAMPLE_BITS-1:0] avg_value_o,
  output logic                             round_done_o,
  output logic signed [asnt_pkg::TEMP_W-1:0] temperature_o
);

  asnt_pkg::scan_rec_t         front_rec, q_rec, out_rec;
  logic                        accept, q_valid, q_pop;
  logic [asnt_pkg::TEMP_W-1:0] out_temp;

  assign accept = push && !full;

  asnt_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .sample_i (sample_i),
    .rec_o    (front_rec)
  );

  asnt_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (accept),
    .wr_data_i  (front_rec),
    .full_o     (full),
    .rd_en_i    (q_pop),
    .rd_valid_o (q_valid),
    .rd_data_o  (q_rec)
  );

  asnt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (q_rec),
    .q_pop_o    (q_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_rec_o  (out_rec),
    .out_temp_o (out_temp)
  );

  assign next_slot_o   = out_rec.next_slot;
  assign avg_valid_o   = out_rec.avg_valid;
  assign avg_slot_o    = out_rec.avg_slot;
  assign avg_value_o   = out_rec.avg_value;
  assign round_done_o  = out_rec.round_done;
  assign temperature_o = $signed(out_temp);

endmodule

// ===== hdl/asnt_front.sv =====
// ============================================================================
// asnt_front: scan sequencer and sample accumulator
// Tracks the scan slot, drops the first beat after a switch, sums the block
// of samples and builds one record per accepted beat.
// ============================================================================
module asnt_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic [asnt_pkg::SAMPLE_BITS-1:0] sample_i,
  output asnt_pkg::scan_rec_t              rec_o
);

  logic [asnt_pkg::SLOT_W-1:0]      slot_q, slot_d;
  logic [asnt_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic [asnt_pkg::SUM_W-1:0]       sum_q, sum_d;
  logic [asnt_pkg::SAMPLE_BITS-1:0] tavg_q, tavg_d;
  logic [asnt_pkg::SUM_W-1:0]       sum_new;

  assign sum_new = sum_q + asnt_pkg::SUM_W'(sample_i);

  always_comb begin
    slot_d = slot_q;
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    tavg_d = tavg_q;
    rec_o  = '0;
    rec_o.temp_code = tavg_q;
    if (cnt_q == '0) begin
      // first beat after a slot switch is settling time
      cnt_d = asnt_pkg::CNT_W'(1);
    end else if (slot_q >= asnt_pkg::SLOT_W'(asnt_pkg::NUM_SLOTS)) begin
      slot_d = '0;
      cnt_d  = '0;
      sum_d  = '0;
    end else if (cnt_q == asnt_pkg::AVG_COUNT) begin
      rec_o.avg_valid = 1'b1;
      rec_o.avg_slot  = slot_q;
      rec_o.avg_value = sum_new[asnt_pkg::SUM_W-1:asnt_pkg::AVG_LOG2];
      cnt_d = '0;
      sum_d = '0;
      if (slot_q == asnt_pkg::SLOT_TEMP) begin
        tavg_d = sum_new[asnt_pkg::SUM_W-1:asnt_pkg::AVG_LOG2];
      end
      if (slot_q == asnt_pkg::SLOT_VOLT) begin
        rec_o.round_done = 1'b1;
        slot_d = '0;
      end else begin
        slot_d = slot_q + asnt_pkg::SLOT_W'(1);
      end
    end else begin
      cnt_d = cnt_q + asnt_pkg::CNT_W'(1);
      sum_d = sum_new;
    end
    rec_o.next_slot = slot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      cnt_q  <= '0;
      sum_q  <= '0;
      tavg_q <= '0;
    end else if (accept_i) begin
      slot_q <= slot_d;
      cnt_q  <= cnt_d;
      sum_q  <= sum_d;
      tavg_q <= tavg_d;
    end
  end

endmodule

// ===== hdl/asnt_fifo.sv =====
// ============================================================================
// asnt_fifo: short record queue between front and back
// Two-entry register queue with full and valid flags.
// ============================================================================
module asnt_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  asnt_pkg::scan_rec_t wr_data_i,
  output logic                full_o,
  input  logic                rd_en_i,
  output logic                rd_valid_o,
  output asnt_pkg::scan_rec_t rd_data_o
);

  asnt_pkg::scan_rec_t           mem_q [asnt_pkg::QDEPTH];
  logic [asnt_pkg::QPTR_W-1:0]   wptr_q, rptr_q;
  logic [asnt_pkg::QCNT_W-1:0]   cnt_q;
  logic                          do_wr, do_rd;

  assign full_o     = (cnt_q == asnt_pkg::QCNT_W'(asnt_pkg::QDEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rptr_q];
  assign do_wr      = wr_en_i && !full_o;
  assign do_rd      = rd_en_i && rd_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= wptr_q + asnt_pkg::QPTR_W'(1);
      end
      if (do_rd) begin
        rptr_q <= rptr_q + asnt_pkg::QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + asnt_pkg::QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - asnt_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/asnt_back.sv =====
// ============================================================================
// asnt_back: temperature conversion and result register
// Ordinary records go straight to the output register; a round-done record
// runs a bitwise table search, an interpolation multiply and a shift-subtract
// divide with round-half-away before it is delivered.
// ============================================================================
module asnt_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  asnt_pkg::scan_rec_t          q_data_i,
  output logic                         q_pop_o,
  input  logic                         pop_i,
  output logic                         empty_o,
  output asnt_pkg::scan_rec_t          out_rec_o,
  output logic [asnt_pkg::TEMP_W-1:0]  out_temp_o
);

  localparam int NUM_W  = 23;
  localparam int PROD_W = 22;
  localparam int DIFF_W = asnt_pkg::SAMPLE_BITS + 1;
  localparam int QUO_W  = asnt_pkg::TEMP_W;

  asnt_pkg::back_state_e state_q, state_d;
  asnt_pkg::scan_rec_t   rec_q;
  asnt_pkg::scan_rec_t   out_q;
  logic [asnt_pkg::TEMP_W-1:0] out_temp_q;
  logic                  out_valid_q;

  logic [asnt_pkg::IDX_W-1:0]       idx_q;
  logic [asnt_pkg::IDX_W-1:0]       bit_q;
  logic [asnt_pkg::SAMPLE_BITS-1:0] d_q;
  logic signed [PROD_W-1:0]         prod_q;
  logic signed [DIFF_W-1:0]         diff_q;
  logic                             neg_q;
  logic [NUM_W-1:0]                 rem_q, dsh_q;
  logic [QUO_W-1:0]                 quo_q;

  logic                             out_free;
  logic                             load_direct, load_done;
  logic [asnt_pkg::IDX_W-1:0]       cand;
  logic                             cand_hit;
  logic [asnt_pkg::SAMPLE_BITS-1:0] rom_lo, rom_hi, d_raw, d_fix;
  logic signed [asnt_pkg::IDX_W:0]  offs;
  logic signed [DIFF_W-1:0]         d_s;
  logic signed [PROD_W-1:0]         prod_w;
  logic signed [DIFF_W-1:0]         diff_w;
  logic [NUM_W-1:0]                 n_w, mag, num;
  logic                             ge;
  logic [QUO_W-1:0]                 temp_res;

  assign out_free = !out_valid_q || pop_i;

  // datapath terms
  always_comb begin
    cand     = idx_q | bit_q;
    cand_hit = (cand <= asnt_pkg::IDX_LAST) &&
               (asnt_pkg::ntc_rom(cand) <= rec_q.temp_code);
    rom_lo   = asnt_pkg::ntc_rom(idx_q);
    rom_hi   = asnt_pkg::ntc_rom(idx_q + asnt_pkg::IDX_W'(1));
    d_raw    = rom_hi - rom_lo;
    d_fix    = (d_raw == '0) ? asnt_pkg::SAMPLE_BITS'(1) : d_raw;
    offs     = $signed({1'b0, idx_q}) - (asnt_pkg::IDX_W+1)'(asnt_pkg::TEMP_OFFSET);
    d_s      = $signed({1'b0, d_fix});
    prod_w   = offs * d_s;
    diff_w   = $signed({1'b0, rec_q.temp_code}) - $signed({1'b0, rom_lo});
    n_w      = {prod_q[PROD_W-1], prod_q} +
               {{(NUM_W-DIFF_W){diff_q[DIFF_W-1]}}, diff_q};
    mag      = n_w[NUM_W-1] ? (NUM_W'(0) - n_w) : n_w;
    num      = {mag[NUM_W-2:0], 1'b0} + NUM_W'(d_q);
    ge       = (rem_q >= dsh_q);
    temp_res = neg_q ? (QUO_W'(0) - quo_q) : quo_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      asnt_pkg::BK_IDLE: begin
        if (q_valid_i && q_data_i.round_done) begin
          state_d = asnt_pkg::BK_SEARCH;
        end
      end
      asnt_pkg::BK_SEARCH: begin
        if (bit_q[0]) begin
          state_d = asnt_pkg::BK_PREP;
        end
      end
      asnt_pkg::BK_PREP: begin
        if (idx_q >= asnt_pkg::IDX_LAST) begin
          state_d = asnt_pkg::BK_DONE;
        end else begin
          state_d = asnt_pkg::BK_NUM;
        end
      end
      asnt_pkg::BK_NUM: state_d = asnt_pkg::BK_DIV;
      asnt_pkg::BK_DIV: begin
        if (bit_q[0]) begin
          state_d = asnt_pkg::BK_DONE;
        end
      end
      asnt_pkg::BK_DONE: begin
        if (out_free) begin
          state_d = asnt_pkg::BK_IDLE;
        end
      end
      default: state_d = asnt_pkg::BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    load_direct = 1'b0;
    load_done   = 1'b0;
    q_pop_o     = 1'b0;
    case (state_q)
      asnt_pkg::BK_IDLE: begin
        load_direct = q_valid_i && !q_data_i.round_done && out_free;
        q_pop_o     = q_valid_i && (q_data_i.round_done || out_free);
      end
      asnt_pkg::BK_DONE: load_done = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= asnt_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_direct || load_done) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      asnt_pkg::BK_IDLE: begin
        rec_q <= q_data_i;
        idx_q <= '0;
        bit_q <= {1'b1, {(asnt_pkg::IDX_W-1){1'b0}}};
      end
      asnt_pkg::BK_SEARCH: begin
        if (cand_hit) begin
          idx_q <= cand;
        end
        bit_q <= bit_q >> 1;
      end
      asnt_pkg::BK_PREP: begin
        d_q    <= d_fix;
        prod_q <= prod_w;
        diff_q <= diff_w;
        // top of the table saturates
        quo_q  <= QUO_W'(asnt_pkg::TEMP_MAX);
        neg_q  <= 1'b0;
      end
      asnt_pkg::BK_NUM: begin
        neg_q <= n_w[NUM_W-1];
        rem_q <= num;
        dsh_q <= NUM_W'({d_q, 1'b0}) << (QUO_W - 1);
        quo_q <= '0;
        bit_q <= {1'b1, {(asnt_pkg::IDX_W-1){1'b0}}};
      end
      asnt_pkg::BK_DIV: begin
        if (ge) begin
          rem_q <= rem_q - dsh_q;
        end
        quo_q <= {quo_q[QUO_W-2:0], ge};
        dsh_q <= dsh_q >> 1;
        bit_q <= bit_q >> 1;
      end
      default: ;
    endcase
    if (load_direct) begin
      out_q      <= q_data_i;
      out_temp_q <= '0;
    end else if (load_done) begin
      out_q      <= rec_q;
      out_temp_q <= temp_res;
    end
  end

  assign empty_o    = !out_valid_q;
  assign out_rec_o  = out_q;
  assign out_temp_o = out_temp_q;

endmodule
